>>> src/trs_pkg.sv
// Package: payload types and the default divider width for the TRS world matrix block.
`timescale 1ns / 1ps
package trs_pkg;

    localparam int DIV_BITS_DEF = 32;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
        logic signed [31:0] scale_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } trs_in_t;

    typedef struct packed {
        logic signed [31:0] axis_x_x;
        logic signed [31:0] axis_x_y;
        logic signed [31:0] axis_x_z;
        logic signed [31:0] axis_y_x;
        logic signed [31:0] axis_y_y;
        logic signed [31:0] axis_y_z;
        logic signed [31:0] axis_z_x;
        logic signed [31:0] axis_z_y;
        logic signed [31:0] axis_z_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } trs_out_t;

endpackage

>>> src/trs_term.sv
// One output term: round(scale * num / den), ties away, saturated, as a pipeline.
`timescale 1ns / 1ps
module trs_term
    import trs_pkg::*;
#(
    parameter int QBITS = DIV_BITS_DEF
)
(
    input  logic               clk,
    input  logic signed [31:0] scale,
    input  logic signed [34:0] num,
    input  logic        [33:0] den,
    output logic signed [31:0] term
);

    // The quotient |s|*|n|/den never exceeds 2^31, so QBITS+1 quotient bits with
    // the top bit kept for rounding overflow. The partial remainder keeps the full product width.
    localparam int STAGES = QBITS + 1;
    localparam int PW     = 66;

    // Stage 0: magnitudes and sign, with |num| clamped to den
    logic [31:0] ms_reg;
    logic [33:0] mn_reg;
    logic [33:0] d0_reg;
    logic        neg0_reg;
    logic [33:0] mn_abs;

    always_comb
    begin
        mn_abs = num[34] ? 34'(-num) : num[33:0];
        if (mn_abs > den)
        begin
            mn_abs = den;
        end
    end

    always_ff @(posedge clk)
    begin
        ms_reg   <= scale[31] ? 32'(-scale) : scale;
        mn_reg   <= mn_abs;
        d0_reg   <= den;
        neg0_reg <= (scale[31] != num[34]) && (scale != 0) && (num != 0);
    end

    // Stage 1: product, split into two 32x17 partial products
    logic [48:0] pl_reg;
    logic [48:0] ph_reg;
    logic [33:0] d1_reg;
    logic        neg1_reg;

    always_ff @(posedge clk)
    begin
        pl_reg   <= {17'd0, ms_reg} * {32'd0, mn_reg[16:0]};
        ph_reg   <= {17'd0, ms_reg} * {32'd0, mn_reg[33:17]};
        d1_reg   <= d0_reg;
        neg1_reg <= neg0_reg;
    end

    // Stage 2: combine partial products
    logic [PW-1:0] p_reg [STAGES+1];
    logic [33:0]   d_reg [STAGES+1];
    logic [STAGES:0] q_reg [STAGES+1];
    logic          ng_reg [STAGES+1];

    always_ff @(posedge clk)
    begin
        p_reg[0]  <= PW'(pl_reg) + (PW'(ph_reg) << 17);
        d_reg[0]  <= d1_reg;
        q_reg[0]  <= '0;
        ng_reg[0] <= neg1_reg;
    end

    // Restoring division, one quotient bit per stage, high bit first.
    // The partial remainder is kept in p_reg and compared against den shifted left.
    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_div
            localparam int SH = STAGES - 1 - g;
            logic [PW+SH-1:0] dsh;
            logic             ge;
            assign dsh = (PW+SH)'(d_reg[g]) << SH;
            assign ge  = (PW+SH)'(p_reg[g]) >= dsh;
            always_ff @(posedge clk)
            begin
                p_reg[g+1]  <= ge ? PW'((PW+SH)'(p_reg[g]) - dsh) : p_reg[g];
                d_reg[g+1]  <= d_reg[g];
                q_reg[g+1]  <= q_reg[g] | ((STAGES+1)'(ge) << SH);
                ng_reg[g+1] <= ng_reg[g];
            end
        end
    endgenerate

    // Final stage: round, saturate, apply sign
    logic [STAGES:0] qr;
    logic [PW-1:0]   rem2;
    logic [31:0]     term_next;

    always_comb
    begin
        rem2 = p_reg[STAGES] << 1;
        qr   = q_reg[STAGES] + (STAGES+1)'(rem2 >= PW'(d_reg[STAGES]));
        if (ng_reg[STAGES])
        begin
            term_next = (qr > (STAGES+1)'(33'h080000000)) ? 32'h80000000 : 32'(-qr);
        end
        else
        begin
            term_next = (qr > (STAGES+1)'(33'h07FFFFFFF)) ? 32'h7FFFFFFF : qr[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        term <= term_next;
    end

endmodule

>>> src/trs_world_matrix_from_quaternion.sv
// Top level: TRS world matrix from position, scale and quaternion.
// Throughput: one item per cycle; the depth is set by the bit-per-stage divider.
// busy is always low; results cannot be stalled and appear on done for one cycle.
// Reset clears only the valid pipeline; payload registers are not reset.
`timescale 1ns / 1ps
module trs_world_matrix_from_quaternion
    import trs_pkg::*;
#(
    parameter int DIV_BITS = DIV_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  trs_in_t  in_item,
    output logic     done,
    output trs_out_t result
);

    localparam int LAT = DIV_BITS + 6;

    assign busy = 1'b0;

    // Stage A: squares and cross products
    logic signed [15:0] w_eff;
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    logic signed [31:0] sx_reg, sy_reg, sz_reg;
    logic               va_reg;

    assign w_eff = (in_item.quat_w == 0 && in_item.quat_x == 0 && in_item.quat_y == 0 &&
                    in_item.quat_z == 0) ? 16'sd1 : in_item.quat_w;

    always_ff @(posedge clk)
    begin
        ww_reg <= w_eff * w_eff;
        xx_reg <= in_item.quat_x * in_item.quat_x;
        yy_reg <= in_item.quat_y * in_item.quat_y;
        zz_reg <= in_item.quat_z * in_item.quat_z;
        xy_reg <= in_item.quat_x * in_item.quat_y;
        wz_reg <= w_eff * in_item.quat_z;
        xz_reg <= in_item.quat_x * in_item.quat_z;
        wy_reg <= w_eff * in_item.quat_y;
        yz_reg <= in_item.quat_y * in_item.quat_z;
        wx_reg <= w_eff * in_item.quat_x;
        sx_reg <= in_item.scale_x;
        sy_reg <= in_item.scale_y;
        sz_reg <= in_item.scale_z;
    end

    // Stage B: numerators and norm
    logic signed [34:0] num_reg [9];
    logic        [33:0] n_reg;
    logic signed [31:0] sc_reg [9];
    logic               vb_reg;

    function automatic logic signed [34:0] sx35(input logic signed [31:0] v);
        sx35 = 35'(v);
    endfunction

    always_ff @(posedge clk)
    begin
        n_reg      <= 34'(sx35(ww_reg) + sx35(xx_reg) + sx35(yy_reg) + sx35(zz_reg));
        num_reg[0] <= sx35(ww_reg) + sx35(xx_reg) - sx35(yy_reg) - sx35(zz_reg);
        num_reg[1] <= (sx35(xy_reg) + sx35(wz_reg)) <<< 1;
        num_reg[2] <= (sx35(xz_reg) - sx35(wy_reg)) <<< 1;
        num_reg[3] <= (sx35(xy_reg) - sx35(wz_reg)) <<< 1;
        num_reg[4] <= sx35(ww_reg) - sx35(xx_reg) + sx35(yy_reg) - sx35(zz_reg);
        num_reg[5] <= (sx35(yz_reg) + sx35(wx_reg)) <<< 1;
        num_reg[6] <= (sx35(xz_reg) + sx35(wy_reg)) <<< 1;
        num_reg[7] <= (sx35(yz_reg) - sx35(wx_reg)) <<< 1;
        num_reg[8] <= sx35(ww_reg) - sx35(xx_reg) - sx35(yy_reg) + sx35(zz_reg);
        for (int i = 0; i < 3; i++)
        begin
            sc_reg[i]   <= sx_reg;
            sc_reg[i+3] <= sy_reg;
            sc_reg[i+6] <= sz_reg;
        end
    end

    // Valid bits and translation travel alongside the term units
    logic [LAT:0]  v_reg;
    logic [95:0]   pos_reg [LAT+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[LAT-1:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg[0] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
        for (int i = 0; i < LAT; i++)
        begin
            pos_reg[i+1] <= pos_reg[i];
        end
    end

    assign va_reg = v_reg[0];
    assign vb_reg = v_reg[1];

    // Nine term units
    logic signed [31:0] t [9];
    genvar k;
    generate
        for (k = 0; k < 9; k++)
        begin : g_term
            trs_term #(.QBITS(DIV_BITS)) u_term (
                .clk     (clk),
                .scale   (sc_reg[k]),
                .num     (num_reg[k]),
                .den     (n_reg),
                .term    (t[k])
            );
        end
    endgenerate

    assign done            = v_reg[LAT];
    assign result.axis_x_x = t[0];
    assign result.axis_x_y = t[1];
    assign result.axis_x_z = t[2];
    assign result.axis_y_x = t[3];
    assign result.axis_y_y = t[4];
    assign result.axis_y_z = t[5];
    assign result.axis_z_x = t[6];
    assign result.axis_z_y = t[7];
    assign result.axis_z_z = t[8];
    assign result.trans_x  = pos_reg[LAT][95:64];
    assign result.trans_y  = pos_reg[LAT][63:32];
    assign result.trans_z  = pos_reg[LAT][31:0];

`ifndef SYNTHESIS
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        va_reg |-> ##(LAT) done) else $error("item lost in pipeline");
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(vb_reg, LAT-1)) else $error("done without item");
`endif

endmodule

>>> test/trs_matrix_checker.sv
// Checker: predicts the TRS world matrix for each accepted item and compares results.
`timescale 1ns / 1ps
module trs_matrix_checker
    import trs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  trs_in_t  in_item,
    input  logic     done,
    input  trs_out_t result,
    output int       fail_count,
    output int       pending
);

    trs_out_t matrix_q[$];

    // round(s * num / den), ties away from zero, saturated to 32 bits
    function automatic logic [31:0] scaled_entry(longint s, longint num, longint unsigned den);
        longint unsigned ms, mn, prod, q, r;
        bit neg;
        ms = (s < 0) ? -s : s;
        mn = (num < 0) ? -num : num;
        neg = (s < 0) != (num < 0);
        if (mn > den) mn = den;
        prod = ms * mn;
        q = prod / den;
        r = prod % den;
        if (r >= den - r) q++;
        if (neg) begin
            if (q > 64'h8000_0000) q = 64'h8000_0000;
            return 32'(-longint'(q));
        end
        if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
        return 32'(q);
    endfunction

    function automatic trs_out_t world_matrix(trs_in_t it);
        trs_out_t o;
        longint w, x, y, z, ww, xx, yy, zz, sx, sy, sz;
        longint unsigned n;
        w = it.quat_w; x = it.quat_x; y = it.quat_y; z = it.quat_z;
        sx = it.scale_x; sy = it.scale_y; sz = it.scale_z;
        // zero quaternion acts as identity
        if (w == 0 && x == 0 && y == 0 && z == 0) w = 1;
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        n = ww + xx + yy + zz;
        o.axis_x_x = scaled_entry(sx, ww + xx - yy - zz, n);
        o.axis_x_y = scaled_entry(sx, 2 * (x * y + w * z), n);
        o.axis_x_z = scaled_entry(sx, 2 * (x * z - w * y), n);
        o.axis_y_x = scaled_entry(sy, 2 * (x * y - w * z), n);
        o.axis_y_y = scaled_entry(sy, ww - xx + yy - zz, n);
        o.axis_y_z = scaled_entry(sy, 2 * (y * z + w * x), n);
        o.axis_z_x = scaled_entry(sz, 2 * (x * z + w * y), n);
        o.axis_z_y = scaled_entry(sz, 2 * (y * z - w * x), n);
        o.axis_z_z = scaled_entry(sz, ww - xx - yy + zz, n);
        o.trans_x = it.pos_x;
        o.trans_y = it.pos_y;
        o.trans_z = it.pos_z;
        return o;
    endfunction

    assign pending = matrix_q.size();

    // predict on accept, compare on done
    always @(posedge clk or negedge rst_n)
    begin
        trs_out_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (done)
            begin
                if (matrix_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result %h", result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = matrix_q.pop_front();
                    if (want !== result)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h got %h", want, result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                matrix_q.push_back(world_matrix(in_item));
        end
    end

endmodule

>>> test/tb.sv
// Testbench top: drives TRS items into the block and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import trs_pkg::*;

    logic     clk = 0;
    logic     rst_n = 0;
    logic     start = 0;
    logic     busy;
    logic     done;
    trs_in_t  in_item = '0;
    trs_out_t result;
    int       fail_count;
    int       pending;
    int       idle_cycles = 0;

    trs_world_matrix_from_quaternion DUT (.*);
    trs_matrix_checker checker_i (.*);

    always #5 clk = ~clk;

    // watchdog: cycles with no item accepted and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0001_0000;
            3: return 32'hFFFF_0000;
            4: return 32'(int'($urandom_range(0, 20'hFFFFF)) - 20'h80000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(int'($urandom_range(0, 8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // hold one item until accepted, with optional random gap first
    task automatic send(trs_in_t it, bit gaps);
        if (gaps)
            while ($urandom_range(0, 99) < 34)
            begin
                start <= 0;
                @(negedge clk);
            end
        start <= 1;
        in_item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_quat(logic [15:0] w, x, y, z, logic [31:0] s, bit gaps);
        trs_in_t it;
        it.pos_x = pick32(); it.pos_y = pick32(); it.pos_z = pick32();
        it.scale_x = s; it.scale_y = s; it.scale_z = s;
        it.quat_w = w; it.quat_x = x; it.quat_y = y; it.quat_z = z;
        send(it, gaps);
    endtask

    initial
    begin
        trs_in_t it;
        int k;
        repeat (4) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        // directed: zero quaternion, axis quaternions, extremes, saturation
        send_quat(16'h0, 16'h0, 16'h0, 16'h0, 32'h0001_0000, 0);
        send_quat(16'h0, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 0);
        send_quat(16'h7FFF, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 0);
        send_quat(16'h8000, 16'h0, 16'h0, 16'h0, 32'h8000_0000, 0);
        send_quat(16'h0, 16'h7FFF, 16'h0, 16'h0, 32'h7FFF_FFFF, 0);
        send_quat(16'h0, 16'h0, 16'h8000, 16'h0, 32'h8000_0000, 0);
        send_quat(16'h0, 16'h0, 16'h0, 16'h8000, 32'h8000_0000, 0);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h7FFF_FFFF, 0);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h8000_0000, 0);
        send_quat(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 0);
        send_quat(16'h1, 16'h1, 16'h0, 16'h0, 32'h0000_0001, 0);
        send_quat(16'h1, 16'h1, 16'h1, 16'h0, 32'h0000_0003, 0);
        send_quat(16'h1, 16'h2, 16'h3, 16'h4, 32'h0000_0001, 0);
        send_quat(16'hFFFF, 16'h1, 16'hFFFF, 16'h1, 32'hFFFF_FFFD, 0);
        send_quat(16'h0, 16'h0, 16'h0, 16'h0, 32'h7FFF_FFFF, 0);
        start <= 0;
        // pause until every expected result has arrived
        while (pending != 0) @(negedge clk);
        // random items: gapped traffic, a burst with no gaps, then gapped traffic again
        for (k = 0; k < 950; k++)
        begin
            it.pos_x = pick32(); it.pos_y = pick32(); it.pos_z = pick32();
            it.scale_x = pick32(); it.scale_y = pick32(); it.scale_z = pick32();
            it.quat_w = pick16(); it.quat_x = pick16();
            it.quat_y = pick16(); it.quat_z = pick16();
            send(it, !(k >= 100 && k < 250));
        end
        start <= 0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
